>>> rtl/rtq_pkg.sv
// ----------------------------------------------------------------------------
// Reorderable ticket queue package
// Shared sizes, codes and types of the reorderable ticket queue.
// ----------------------------------------------------------------------------
package rtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_BITS = 32;

    localparam int PORT_BITS = 32;
    localparam int STORE_HANDLE_BITS = (HANDLE_BITS < PORT_BITS) ? HANDLE_BITS : PORT_BITS;
    localparam int SLOT_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_BITS = 4;
    localparam int CMP_BITS = ((COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS) + 1;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_SERVICE = 2'd1,
        ACT_UP      = 2'd2,
        ACT_DOWN    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_EMPTY_PAYLOAD = 3'd1,
        ST_QUEUE_EMPTY   = 3'd2,
        ST_BAD_POSITION  = 3'd3,
        ST_QUEUE_FULL    = 3'd4
    } status_t;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_CHECK   = 7'b0000010,
        S_READ_A  = 7'b0000100,
        S_READ_B  = 7'b0001000,
        S_WRITE_A = 7'b0010000,
        S_WRITE_B = 7'b0100000,
        S_POP     = 7'b1000000
    } state_t;

    typedef struct packed {
        logic [PORT_BITS-1:0]         number;
        logic [STORE_HANDLE_BITS-1:0] customer;
        logic [STORE_HANDLE_BITS-1:0] complaint;
    } entry_t;

endpackage

>>> rtl/reorderable_ticket_queue.sv
// ----------------------------------------------------------------------------
// Reorderable ticket queue
// Bounded ticket FIFO with add, service and adjacent swap, run by a small
// sequencer around a one-read, one-write entry store and one shared slot adder.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | action, position, customer_ref, complaint_ref
//  out     | out_valid / out_ready | status, ticket_number, out_customer,
//          |                       | out_complaint, entry_count
//
// An accepted transaction first passes a check step, where a refused
// operation finishes. An add then writes its entry, a service reads the front
// entry and pops it, and a move reads both entries and writes them back
// swapped. One transaction is in flight at a time, and in_ready returns once
// the result has been taken. Reset empties the queue at once; the entry store
// itself is not cleared. A stalled result holds its value.
// ----------------------------------------------------------------------------
module reorderable_ticket_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [3:0]  position,
    input  logic [31:0] customer_ref,
    input  logic [31:0] complaint_ref,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] ticket_number,
    output logic [31:0] out_customer,
    output logic [31:0] out_complaint,
    output logic [4:0]  entry_count
);

    localparam int SB = rtq_pkg::SLOT_BITS;
    localparam int CB = rtq_pkg::COUNT_BITS;
    localparam int HB = rtq_pkg::STORE_HANDLE_BITS;
    localparam int PB = rtq_pkg::PORT_BITS;
    localparam int MB = rtq_pkg::CMP_BITS;
    localparam int ENTRY_BITS = $bits(rtq_pkg::entry_t);

    rtq_pkg::state_t  state_reg, state_next;
    rtq_pkg::action_t op_reg;
    logic [rtq_pkg::POS_BITS-1:0] pos_reg;
    logic [HB-1:0] cust_reg, comp_reg;

    logic [SB-1:0] head_reg, head_next;
    logic [CB-1:0] held_reg, held_next;
    logic [PB-1:0] last_reg, last_next;
    logic [SB-1:0] addr_a_reg, addr_a_next;
    logic [SB-1:0] addr_b_reg, addr_b_next;

    logic [ENTRY_BITS-1:0] mem [rtq_pkg::QUEUE_DEPTH];
    rtq_pkg::entry_t rd_data_reg, hold_a_reg;
    logic            mem_we, mem_re;
    logic [SB-1:0]   mem_waddr, mem_raddr;
    rtq_pkg::entry_t mem_wdata;

    logic [SB-1:0] unit_base, unit_off, unit_sum;
    logic [SB:0]   unit_raw;

    logic             out_valid_reg;
    rtq_pkg::status_t status_reg;
    logic [PB-1:0]    number_reg, out_cust_reg, out_comp_reg;
    logic [CB-1:0]    count_reg;

    logic             finish;
    rtq_pkg::status_t res_status;
    logic [PB-1:0]    res_number, res_cust, res_comp;

    logic [MB-1:0] pos_wide, held_wide;
    logic [PB-1:0] last_inc;
    logic          accept;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == rtq_pkg::S_IDLE) && !out_valid_reg;
    assign pos_wide  = MB'(pos_reg);
    assign held_wide = MB'(held_reg);
    assign last_inc  = last_reg + PB'(1);

    assign unit_raw = {1'b0, unit_base} + {1'b0, unit_off};
    assign unit_sum = (unit_raw >= (SB + 1)'(rtq_pkg::QUEUE_DEPTH))
                    ? SB'(unit_raw - (SB + 1)'(rtq_pkg::QUEUE_DEPTH))
                    : SB'(unit_raw);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        held_next   = held_reg;
        last_next   = last_reg;
        addr_a_next = addr_a_reg;
        addr_b_next = addr_b_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = addr_a_reg;
        mem_raddr   = addr_a_reg;
        mem_wdata   = rd_data_reg;
        unit_base   = head_reg;
        unit_off    = '0;
        finish      = 1'b0;
        res_status  = rtq_pkg::ST_OK;
        res_number  = '0;
        res_cust    = '0;
        res_comp    = '0;
        case (state_reg)
            rtq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = rtq_pkg::S_CHECK;
                end
            end
            rtq_pkg::S_CHECK:
            begin
                case (op_reg)
                    rtq_pkg::ACT_ADD:
                    begin
                        unit_off = SB'(held_reg);
                        if (cust_reg == '0 || comp_reg == '0)
                        begin
                            finish     = 1'b1;
                            res_status = rtq_pkg::ST_EMPTY_PAYLOAD;
                        end
                        else if (held_reg >= CB'(rtq_pkg::QUEUE_DEPTH))
                        begin
                            finish     = 1'b1;
                            res_status = rtq_pkg::ST_QUEUE_FULL;
                        end
                        else
                        begin
                            addr_a_next = unit_sum;
                            state_next  = rtq_pkg::S_WRITE_A;
                        end
                    end
                    rtq_pkg::ACT_SERVICE:
                    begin
                        if (held_reg == '0)
                        begin
                            finish     = 1'b1;
                            res_status = rtq_pkg::ST_QUEUE_EMPTY;
                        end
                        else
                        begin
                            addr_a_next = unit_sum;
                            state_next  = rtq_pkg::S_READ_A;
                        end
                    end
                    rtq_pkg::ACT_UP:
                    begin
                        unit_off = SB'(pos_reg);
                        if (pos_reg == '0 || pos_wide >= held_wide)
                        begin
                            finish     = 1'b1;
                            res_status = rtq_pkg::ST_BAD_POSITION;
                        end
                        else
                        begin
                            addr_a_next = unit_sum;
                            state_next  = rtq_pkg::S_READ_A;
                        end
                    end
                    default:
                    begin
                        unit_off = SB'(pos_reg);
                        if (pos_wide + MB'(1) >= held_wide)
                        begin
                            finish     = 1'b1;
                            res_status = rtq_pkg::ST_BAD_POSITION;
                        end
                        else
                        begin
                            addr_a_next = unit_sum;
                            state_next  = rtq_pkg::S_READ_A;
                        end
                    end
                endcase
            end
            rtq_pkg::S_READ_A:
            begin
                mem_re    = 1'b1;
                mem_raddr = addr_a_reg;
                unit_base = addr_a_reg;
                unit_off  = (op_reg == rtq_pkg::ACT_UP) ? SB'(rtq_pkg::QUEUE_DEPTH - 1) : SB'(1);
                addr_b_next = unit_sum;
                state_next  = (op_reg == rtq_pkg::ACT_SERVICE) ? rtq_pkg::S_POP
                                                               : rtq_pkg::S_READ_B;
            end
            rtq_pkg::S_READ_B:
            begin
                mem_re     = 1'b1;
                mem_raddr  = addr_b_reg;
                state_next = rtq_pkg::S_WRITE_A;
            end
            rtq_pkg::S_WRITE_A:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_a_reg;
                if (op_reg == rtq_pkg::ACT_ADD)
                begin
                    mem_wdata.number    = last_inc;
                    mem_wdata.customer  = cust_reg;
                    mem_wdata.complaint = comp_reg;
                    last_next  = last_inc;
                    held_next  = held_reg + CB'(1);
                    finish     = 1'b1;
                    res_number = last_inc;
                end
                else
                begin
                    state_next = rtq_pkg::S_WRITE_B;
                end
            end
            rtq_pkg::S_WRITE_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_b_reg;
                mem_wdata = hold_a_reg;
                finish    = 1'b1;
            end
            rtq_pkg::S_POP:
            begin
                unit_base  = addr_a_reg;
                unit_off   = SB'(1);
                head_next  = unit_sum;
                held_next  = held_reg - CB'(1);
                finish     = 1'b1;
                res_number = rd_data_reg.number;
                res_cust   = PB'(rd_data_reg.customer);
                res_comp   = PB'(rd_data_reg.complaint);
            end
            default:
            begin
                state_next = rtq_pkg::S_IDLE;
            end
        endcase
        if (finish)
        begin
            state_next = rtq_pkg::S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtq_pkg::S_IDLE;
            head_reg      <= '0;
            held_reg      <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            held_reg  <= held_next;
            last_reg  <= last_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= rtq_pkg::action_t'(action);
            pos_reg  <= position;
            cust_reg <= customer_ref[HB-1:0];
            comp_reg <= complaint_ref[HB-1:0];
        end
        addr_a_reg <= addr_a_next;
        addr_b_reg <= addr_b_next;
        if (finish)
        begin
            status_reg   <= res_status;
            number_reg   <= res_number;
            out_cust_reg <= res_cust;
            out_comp_reg <= res_comp;
            count_reg    <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
        if (state_reg == rtq_pkg::S_READ_B)
        begin
            hold_a_reg <= rd_data_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign ticket_number = number_reg;
    assign out_customer  = out_cust_reg;
    assign out_complaint = out_comp_reg;
    assign entry_count   = 5'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CB'(rtq_pkg::QUEUE_DEPTH))
        else $error("Ticket count exceeds the queue depth.");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rtq_pkg::S_IDLE) |-> !in_ready)
        else $error("Input ready while the sequencer is busy.");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == rtq_pkg::S_CHECK))
        else $error("Accepted transaction did not start the check step.");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (count_reg == held_reg))
        else $error("Reported count differs from the held count.");

endmodule

>>> test/tb_reorderable_ticket_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reorderable ticket queue testbench
// Drives add, service and swap requests through the valid/ready channels and
// checks every result against a local model of the ticket queue. Both sides
// idle at random. A short list of boundary cases runs first, followed by fill,
// drain, mixed and reorder-heavy random phases.
// ----------------------------------------------------------------------------
module tb_reorderable_ticket_queue;

    localparam int RANDOM_REQUESTS = 550;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [31:0] HANDLE_MASK =
        (rtq_pkg::HANDLE_BITS >= 32) ? 32'hFFFF_FFFF
                                     : ((32'h1 << rtq_pkg::HANDLE_BITS) - 32'h1);

    typedef struct {
        rtq_pkg::action_t op;
        logic [3:0]       pos;
        logic [31:0]      customer;
        logic [31:0]      complaint;
    } ticket_request_t;

    typedef struct {
        rtq_pkg::status_t status;
        logic [31:0]      number;
        logic [31:0]      customer;
        logic [31:0]      complaint;
        logic [4:0]       count;
    } ticket_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = rtq_pkg::ACT_ADD;
    logic [3:0]  position = 4'd0;
    logic [31:0] customer_ref = 32'd0;
    logic [31:0] complaint_ref = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] ticket_number;
    logic [31:0] out_customer;
    logic [31:0] out_complaint;
    logic [4:0]  entry_count;

    ticket_request_t request_backlog[$];
    ticket_result_t  expected_tickets[$];

    logic [31:0] held_number[rtq_pkg::QUEUE_DEPTH];
    logic [31:0] held_customer[rtq_pkg::QUEUE_DEPTH];
    logic [31:0] held_complaint[rtq_pkg::QUEUE_DEPTH];
    int          front_slot = 0;
    int          held_total = 0;
    logic [31:0] last_issued = 32'd0;

    int error_count = 0;
    int total_requests = 0;
    int results_checked = 0;
    int cycle_count = 0;
    int planned_count = 0;
    int source_wait = 0;
    int sink_wait = 0;
    bit source_steady = 1'b0;
    bit sink_steady = 1'b0;

    reorderable_ticket_queue dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .position      (position),
        .customer_ref  (customer_ref),
        .complaint_ref (complaint_ref),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .ticket_number (ticket_number),
        .out_customer  (out_customer),
        .out_complaint (out_complaint),
        .entry_count   (entry_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic int slot_at(input int pos);
        return (front_slot + pos) % rtq_pkg::QUEUE_DEPTH;
    endfunction

    function automatic void swap_entries(input int a, input int b);
        logic [31:0] num;
        logic [31:0] cust;
        logic [31:0] comp;
        num = held_number[a];
        cust = held_customer[a];
        comp = held_complaint[a];
        held_number[a] = held_number[b];
        held_customer[a] = held_customer[b];
        held_complaint[a] = held_complaint[b];
        held_number[b] = num;
        held_customer[b] = cust;
        held_complaint[b] = comp;
    endfunction

    task automatic predict_ticket_op(input ticket_request_t req, output ticket_result_t res);
        logic [31:0] cust;
        logic [31:0] comp;
        int          s;
        int          pos;
        cust = req.customer & HANDLE_MASK;
        comp = req.complaint & HANDLE_MASK;
        pos = int'(req.pos);
        res.status = rtq_pkg::ST_OK;
        res.number = 32'd0;
        res.customer = 32'd0;
        res.complaint = 32'd0;
        case (req.op)
            rtq_pkg::ACT_ADD:
            begin
                if (cust == 32'd0 || comp == 32'd0)
                    res.status = rtq_pkg::ST_EMPTY_PAYLOAD;
                else if (held_total >= rtq_pkg::QUEUE_DEPTH)
                    res.status = rtq_pkg::ST_QUEUE_FULL;
                else
                begin
                    s = slot_at(held_total);
                    last_issued = last_issued + 32'd1;
                    held_number[s] = last_issued;
                    held_customer[s] = cust;
                    held_complaint[s] = comp;
                    held_total++;
                    res.number = last_issued;
                end
            end
            rtq_pkg::ACT_SERVICE:
            begin
                if (held_total == 0)
                    res.status = rtq_pkg::ST_QUEUE_EMPTY;
                else
                begin
                    s = slot_at(0);
                    res.number = held_number[s];
                    res.customer = held_customer[s];
                    res.complaint = held_complaint[s];
                    front_slot = slot_at(1);
                    held_total--;
                end
            end
            rtq_pkg::ACT_UP:
            begin
                if (pos == 0 || pos >= held_total)
                    res.status = rtq_pkg::ST_BAD_POSITION;
                else
                    swap_entries(slot_at(pos), slot_at(pos - 1));
            end
            default:
            begin
                if (pos + 1 >= held_total)
                    res.status = rtq_pkg::ST_BAD_POSITION;
                else
                    swap_entries(slot_at(pos), slot_at(pos + 1));
            end
        endcase
        res.count = held_total[4:0];
    endtask

    task automatic queue_request(input rtq_pkg::action_t op, input int pos,
                                 input logic [31:0] cust, input logic [31:0] comp);
        ticket_request_t req;
        req.op = op;
        req.pos = pos[3:0];
        req.customer = cust;
        req.complaint = comp;
        request_backlog.push_back(req);
        if (op == rtq_pkg::ACT_ADD && cust != 32'd0 && comp != 32'd0
            && planned_count < rtq_pkg::QUEUE_DEPTH)
            planned_count++;
        else if (op == rtq_pkg::ACT_SERVICE && planned_count > 0)
            planned_count--;
    endtask

    function automatic logic [31:0] draw_handle();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 32'hFFFF_FFFF;
        else if (pick == 1)
            return 32'd1;
        else if (pick == 2)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic int draw_idle(input bit steady);
        if (steady)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    task automatic build_stimulus();
        int               phase;
        int               pick;
        int               pos;
        rtq_pkg::action_t op;
        logic [31:0]      cust;
        logic [31:0]      comp;
        int               add_w;
        int               svc_w;
        int               up_w;

        queue_request(rtq_pkg::ACT_SERVICE, 0, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_UP, 0, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_DOWN, 15, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_DOWN, 0, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_ADD, 0, 32'd0, 32'd5);
        queue_request(rtq_pkg::ACT_ADD, 0, 32'd5, 32'd0);
        queue_request(rtq_pkg::ACT_ADD, 0, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_ADD, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(rtq_pkg::ACT_ADD, 0, 32'd1, 32'd1);
        queue_request(rtq_pkg::ACT_ADD, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        queue_request(rtq_pkg::ACT_UP, 0, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_UP, 3, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_UP, 2, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_DOWN, 2, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_DOWN, 0, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_UP, 1, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_SERVICE, 0, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_SERVICE, 0, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_SERVICE, 0, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_SERVICE, 0, 32'd0, 32'd0);
        queue_request(rtq_pkg::ACT_UP, 15, 32'd0, 32'd0);

        phase = 0;
        add_w = 35;
        svc_w = 30;
        up_w = 17;
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 40 == 0)
            begin
                phase = $urandom_range(0, 3);
                case (phase)
                    0:
                    begin
                        add_w = 70;
                        svc_w = 10;
                        up_w = 10;
                    end
                    1:
                    begin
                        add_w = 15;
                        svc_w = 65;
                        up_w = 10;
                    end
                    2:
                    begin
                        add_w = 35;
                        svc_w = 30;
                        up_w = 17;
                    end
                    default:
                    begin
                        add_w = 20;
                        svc_w = 10;
                        up_w = 35;
                    end
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < add_w)
                op = rtq_pkg::ACT_ADD;
            else if (pick < add_w + svc_w)
                op = rtq_pkg::ACT_SERVICE;
            else if (pick < add_w + svc_w + up_w)
                op = rtq_pkg::ACT_UP;
            else
                op = rtq_pkg::ACT_DOWN;

            if ($urandom_range(0, 3) != 0 && planned_count > 0)
                pos = $urandom_range(0, planned_count - 1);
            else
                pos = $urandom_range(0, 15);

            cust = draw_handle();
            comp = draw_handle();
            pick = $urandom_range(0, 99);
            if (pick < 3)
                cust = 32'd0;
            else if (pick < 6)
                comp = 32'd0;
            else if (pick < 7)
            begin
                cust = 32'd0;
                comp = 32'd0;
            end
            queue_request(op, pos, cust, comp);
        end
        total_requests = request_backlog.size();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ticket_request_t taken;
        ticket_request_t next_req;
        ticket_result_t  want;
        int              gap;
        bit              launch;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= rtq_pkg::ACT_ADD;
            position <= 4'd0;
            customer_ref <= 32'd0;
            complaint_ref <= 32'd0;
            source_wait <= 0;
        end
        else
        begin
            launch = 1'b0;
            if (in_valid && in_ready)
            begin
                taken.op = rtq_pkg::action_t'(action);
                taken.pos = position;
                taken.customer = customer_ref;
                taken.complaint = complaint_ref;
                predict_ticket_op(taken, want);
                expected_tickets.push_back(want);
                if ($urandom_range(0, 29) == 0)
                    source_steady = !source_steady;
                gap = draw_idle(source_steady);
                if (gap == 0 && request_backlog.size() > 0)
                    launch = 1'b1;
                else
                begin
                    in_valid <= 1'b0;
                    source_wait <= gap;
                end
            end
            else if (!in_valid)
            begin
                if (source_wait > 0)
                    source_wait <= source_wait - 1;
                else if (request_backlog.size() > 0)
                    launch = 1'b1;
            end
            if (launch)
            begin
                next_req = request_backlog.pop_front();
                in_valid <= 1'b1;
                action <= next_req.op;
                position <= next_req.pos;
                customer_ref <= next_req.customer;
                complaint_ref <= next_req.complaint;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        ticket_result_t want;
        int             stall;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_wait <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (expected_tickets.size() == 0)
                report_mismatch($sformatf("unexpected result, status %0d count %0d",
                                          status, entry_count));
            else
            begin
                want = expected_tickets.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("result %0d status got %0d want %0d",
                                              results_checked, status, want.status));
                if (ticket_number !== want.number)
                    report_mismatch($sformatf("result %0d ticket_number got %0h want %0h",
                                              results_checked, ticket_number, want.number));
                if (out_customer !== want.customer)
                    report_mismatch($sformatf("result %0d out_customer got %0h want %0h",
                                              results_checked, out_customer, want.customer));
                if (out_complaint !== want.complaint)
                    report_mismatch($sformatf("result %0d out_complaint got %0h want %0h",
                                              results_checked, out_complaint, want.complaint));
                if (entry_count !== want.count)
                    report_mismatch($sformatf("result %0d entry_count got %0d want %0d",
                                              results_checked, entry_count, want.count));
                results_checked++;
            end
            if ($urandom_range(0, 29) == 0)
                sink_steady = !sink_steady;
            stall = draw_idle(sink_steady);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                sink_wait <= stall - 1;
            end
        end
        else if (!out_ready)
        begin
            if (sink_wait > 0)
                sink_wait <= sink_wait - 1;
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        build_stimulus();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (results_checked < total_requests)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_tickets.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_tickets.size()));
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
